@@ rtl/core/uv_sphere_cell_tessellator_top_defines.svh @@
// Assertion macros shared by the tessellator RTL.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef UV_SPHERE_CELL_TESSELLATOR_TOP_DEFINES_SVH
`define UV_SPHERE_CELL_TESSELLATOR_TOP_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define UVST_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define UVST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/uvst_pkg.sv @@
// Shared types, constants and helper functions of the UV sphere tessellator.
// No dependencies.
`default_nettype none

package uvst_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int MAX_DIV      = 256;
  localparam int DIV_W        = 9;
  localparam int NUM_W        = 25;
  localparam int CW           = 34;  // CORDIC datapath width
  localparam int TRIG_W       = 17;
  localparam int POS_W        = 17;
  localparam int BASE_W       = 18;
  localparam int PROD_W       = 36;
  localparam int ACC_W        = 50;

  localparam logic [4:0] DIV_LAST    = 5'd25;
  localparam logic [4:0] CORDIC_LAST = 5'd15;
  localparam logic [4:0] MUL_LAST    = 5'd8;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_STACKS   = 2'd1;
  localparam logic [1:0] REG_SEGMENTS = 2'd2;

  localparam logic [2:0] RES_LAST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CINIT,
    ST_CORDIC,
    ST_STORE,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       div_init;
    logic       div_step;
    logic       cordic_init;
    logic       cordic_step;
    logic       trig_store;
    logic       mul_step;
    logic       adv_base;
    logic [1:0] ang;   // 0/1 stack i/i+1, 2/3 segment j/j+1
    logic [4:0] step;
    logic [2:0] res;   // result number within the cell
  } cmd_t;

  // atan(2^-k), 2^32 units per turn
  function automatic logic signed [CW-1:0] atan_lut(input logic [3:0] k);
    logic signed [CW-1:0] v;
    unique case (k)
      4'd0:  v = 34'sd536870912;
      4'd1:  v = 34'sd316933406;
      4'd2:  v = 34'sd167458907;
      4'd3:  v = 34'sd85004756;
      4'd4:  v = 34'sd42667331;
      4'd5:  v = 34'sd21354465;
      4'd6:  v = 34'sd10679838;
      4'd7:  v = 34'sd5340245;
      4'd8:  v = 34'sd2670163;
      4'd9:  v = 34'sd1335087;
      4'd10: v = 34'sd667544;
      4'd11: v = 34'sd333772;
      4'd12: v = 34'sd166886;
      4'd13: v = 34'sd83443;
      4'd14: v = 34'sd41722;
      4'd15: v = 34'sd20861;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] elem_offset(input logic [2:0] res);
    logic [1:0] v;
    case (res)
      3'd0:    v = 2'd0;
      3'd1:    v = 2'd1;
      3'd2:    v = 2'd2;
      3'd3:    v = 2'd2;
      3'd4:    v = 2'd1;
      default: v = 2'd3;
    endcase
    return v;
  endfunction

  function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] d);
    logic [DIV_W-1:0] v;
    if (d == '0) v = 9'd1;
    else if (d > 9'(MAX_DIV)) v = 9'(MAX_DIV);
    else v = d;
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [23:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 24'sd65535) r = 17'sh0FFFF;
    else if (v < -24'sd65536) r = 17'sh10000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/uv_sphere_cell_tessellator_top.sv @@
// UV sphere cell tessellator, top level.
// Input channel: one cell per transaction, in_tdata = {segment_index, stack_index},
// in_tuser = start_mesh (clears the running vertex base before this cell).
// Output channel: six transactions per cell. The first four carry corner vertices
// (i,j), (i+1,j), (i,j+1), (i+1,j+1) with out_tuser = 1; the last two carry only
// element indices. out_tlast marks the sixth. Element indices run base+0,1,2,2,1,3
// and the base advances by 4 per cell.
// Sequence: the four sine/cosine pairs each come from a restoring divider for the
// angle followed by a 16-step CORDIC; each corner then runs its products on a
// shared 18x18 multiplier. A new cell is accepted only after the sixth result is
// taken, so the block never works on two cells at once.
// Reset (rst_n low, synchronous) loads radius 1.0, 16 stacks, 32 segments and
// clears the vertex base. When the receiver stalls, the offered result holds and
// the block waits. Configuration writes are taken any cycle but belong in idle time.
// Depends on uvst_pkg, uvst_ctrl and uvst_dp.
`default_nettype none

module uv_sphere_cell_tessellator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] stack_index, [15:8] segment_index
  input  wire logic        in_tuser,   // [0] start_mesh
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [1:0] corner_number, [18:2] pos_x, [35:19] pos_y,
                                       // [52:36] pos_z, [70:53] element_index, [71] zero
  output logic             out_tuser,  // [0] vertex_valid
  output logic             out_tlast   // last_of_cell
);

  uvst_pkg::cmd_t cmd;

  uvst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  uvst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/uvst_dp.sv @@
// Datapath: config registers, angle divider, CORDIC, multiplier and result fields.
// Depends on uvst_pkg; sequenced by uvst_ctrl through uvst_pkg::cmd_t.
`default_nettype none

module uvst_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic [15:0]         in_tdata,
  input  wire logic                in_tuser,
  input  wire uvst_pkg::cmd_t      cmd,
  output logic [71:0]              out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);

  logic [15:0] radius_r;
  logic [8:0]  stacks_r;
  logic [8:0]  segs_r;
  logic [7:0]  i_r;
  logic [7:0]  j_r;
  logic [uvst_pkg::BASE_W-1:0] base_r;

  // configuration and item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      stacks_r <= 9'd16;
      segs_r   <= 9'd32;
      base_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          uvst_pkg::REG_RADIUS:   radius_r <= cfg_wdata;
          uvst_pkg::REG_STACKS:   stacks_r <= cfg_wdata[8:0];
          uvst_pkg::REG_SEGMENTS: segs_r   <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (cmd.load_item && in_tuser) base_r <= '0;
      else if (cmd.adv_base) base_r <= base_r + 18'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      i_r <= in_tdata[7:0];
      j_r <= in_tdata[15:8];
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [uvst_pkg::DIV_W-1:0] dvs;
  logic [8:0]  nidx;
  logic [uvst_pkg::NUM_W-1:0] num_init;
  logic [uvst_pkg::NUM_W-1:0] num_r;
  logic [8:0]  rem_r;
  logic [15:0] quo_r;
  logic [9:0]  rem_sh;
  logic        q_bit;

  always_comb begin
    dvs  = cmd.ang[1] ? uvst_pkg::clamp_div(segs_r) : uvst_pkg::clamp_div(stacks_r);
    nidx = cmd.ang[1] ? ({1'b0, j_r} + {8'd0, cmd.ang[0]})
                      : ({1'b0, i_r} + {8'd0, cmd.ang[0]});
    if (cmd.ang[1]) num_init = {nidx, 16'd0} + {16'd0, 1'b0, dvs[8:1]};
    else num_init = {1'b0, nidx, 15'd0} + {16'd0, 1'b0, dvs[8:1]};
    rem_sh = {rem_r, num_r[uvst_pkg::NUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= num_init;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[uvst_pkg::NUM_W-2:0], 1'b0};
      rem_r <= q_bit ? 9'(rem_sh - {1'b0, dvs}) : rem_sh[8:0];
      quo_r <= {quo_r[14:0], q_bit};
    end
  end

  // CORDIC, rotation mode, after a half-turn fold
  logic [15:0] ang16;
  logic        fold;
  logic [15:0] ang_f;
  logic signed [uvst_pkg::CW-1:0] cx_r, cy_r, cz_r;
  logic        neg_r;
  logic signed [uvst_pkg::CW-1:0] dx, dy, at;
  logic signed [uvst_pkg::CW-1:0] csum, ssum, csh, ssh;
  logic signed [17:0] cr, sr, cn, sn;

  always_comb begin
    ang16 = cmd.ang[1] ? quo_r : (16'h4000 - quo_r);
    fold  = ang16[15] ^ ang16[14];  // bit 15 of ang16 + quarter turn
    ang_f = fold ? (ang16 ^ 16'h8000) : ang16;
    dx    = cy_r >>> cmd.step[3:0];
    dy    = cx_r >>> cmd.step[3:0];
    at    = uvst_pkg::atan_lut(cmd.step[3:0]);
    csum  = cx_r + 34'sd16384;
    ssum  = cy_r + 34'sd16384;
    csh   = csum >>> 15;
    ssh   = ssum >>> 15;
    cr    = csh[17:0];
    sr    = ssh[17:0];
    cn    = neg_r ? -cr : cr;
    sn    = neg_r ? -sr : sr;
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx_r  <= uvst_pkg::CORDIC_GAIN;
      cy_r  <= '0;
      cz_r  <= {{2{ang_f[15]}}, ang_f, 16'd0};
      neg_r <= fold;
    end else if (cmd.cordic_step) begin
      if (!cz_r[uvst_pkg::CW-1]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end
    end
  end

  logic signed [uvst_pkg::TRIG_W-1:0] st0_cos_r, st0_sin_r, st1_cos_r, st1_sin_r;
  logic signed [uvst_pkg::TRIG_W-1:0] sg0_cos_r, sg0_sin_r, sg1_cos_r, sg1_sin_r;

  always_ff @(posedge clk) begin
    if (cmd.trig_store) begin
      unique case (cmd.ang)
        2'd0: begin st0_cos_r <= cn[16:0]; st0_sin_r <= sn[16:0]; end
        2'd1: begin st1_cos_r <= cn[16:0]; st1_sin_r <= sn[16:0]; end
        2'd2: begin sg0_cos_r <= cn[16:0]; sg0_sin_r <= sn[16:0]; end
        2'd3: begin sg1_cos_r <= cn[16:0]; sg1_sin_r <= sn[16:0]; end
      endcase
    end
  end

  // shared 18x18 multiplier; r*cos(stack)*trig(seg) is split over two products
  logic signed [uvst_pkg::TRIG_W-1:0] sst, cst, ssg, csg;
  logic signed [17:0] mul_a, mul_b, r18, lo18, hi18;
  logic signed [uvst_pkg::PROD_W-1:0] prod, prod_r;
  logic signed [33:0] rc_r;
  logic signed [uvst_pkg::ACC_W-1:0] acc_r, prod_ext;
  logic signed [uvst_pkg::PROD_W-1:0] p15;
  logic signed [uvst_pkg::ACC_W-1:0] a30;
  logic signed [uvst_pkg::POS_W-1:0] px_r, py_r, pz_r;

  always_comb begin
    sst  = cmd.res[0] ? st1_sin_r : st0_sin_r;
    cst  = cmd.res[0] ? st1_cos_r : st0_cos_r;
    ssg  = cmd.res[1] ? sg1_sin_r : sg0_sin_r;
    csg  = cmd.res[1] ? sg1_cos_r : sg0_cos_r;
    r18  = {2'b00, radius_r};
    lo18 = {1'b0, rc_r[16:0]};
    hi18 = {rc_r[33], rc_r[33:17]};
    unique case (cmd.step[3:0])
      4'd0:    begin mul_a = r18;  mul_b = 18'(sst); end
      4'd3:    begin mul_a = lo18; mul_b = 18'(ssg); end
      4'd4:    begin mul_a = hi18; mul_b = 18'(ssg); end
      4'd5:    begin mul_a = lo18; mul_b = 18'(csg); end
      4'd6:    begin mul_a = hi18; mul_b = 18'(csg); end
      default: begin mul_a = r18;  mul_b = 18'(cst); end
    endcase
    prod     = mul_a * mul_b;
    prod_ext = 50'(prod_r);
    p15      = (prod_r + 36'sd16384) >>> 15;
    a30      = (acc_r + 50'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      prod_r <= prod;
      unique case (cmd.step[3:0])
        4'd1: py_r  <= uvst_pkg::sat_pos(p15[23:0]);
        4'd2: rc_r  <= prod_r[33:0];
        4'd4: acc_r <= prod_ext;
        4'd5: acc_r <= acc_r + (prod_ext <<< 17);
        4'd6: begin
          px_r  <= uvst_pkg::sat_pos(a30[23:0]);
          acc_r <= prod_ext;
        end
        4'd7: acc_r <= acc_r + (prod_ext <<< 17);
        4'd8: pz_r  <= uvst_pkg::sat_pos(a30[23:0]);
        default: ;
      endcase
    end
  end

  // result fields, held stable by the controller while a result is offered
  logic        vtx;
  logic [uvst_pkg::BASE_W-1:0] elem;

  always_comb begin
    vtx       = (cmd.res < 3'd4);
    elem      = base_r + {16'd0, uvst_pkg::elem_offset(cmd.res)};
    out_tuser = vtx;
    out_tlast = (cmd.res == uvst_pkg::RES_LAST);
    out_tdata = {1'b0, elem,
                 vtx ? pz_r : 17'd0,
                 vtx ? py_r : 17'd0,
                 vtx ? px_r : 17'd0,
                 vtx ? cmd.res[1:0] : 2'd0};
  end

endmodule

`default_nettype wire

@@ rtl/core/uvst_ctrl.sv @@
// Controller FSM: sequences divider, CORDIC, multiplier steps and result handshakes.
// Depends on uvst_pkg and uv_sphere_cell_tessellator_top_defines.svh.
`default_nettype none
`include "uv_sphere_cell_tessellator_top_defines.svh"

module uvst_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output uvst_pkg::cmd_t      cmd
);

  uvst_pkg::state_t state_r, state_nxt;
  logic [1:0] ang_r, ang_nxt;
  logic [4:0] step_r, step_nxt;
  logic [2:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uvst_pkg::ST_IDLE;
      ang_r   <= '0;
      step_r  <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ang_r   <= ang_nxt;
      step_r  <= step_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ang_nxt    = ang_r;
    step_nxt   = step_r;
    res_nxt    = res_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    cmd.ang    = ang_r;
    cmd.step   = step_r;
    cmd.res    = res_r;
    unique case (state_r)
      uvst_pkg::ST_IDLE: begin
        // no transaction is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load_item = 1'b1;
          ang_nxt   = '0;
          step_nxt  = '0;
          res_nxt   = '0;
          state_nxt = uvst_pkg::ST_DIV;
        end
      end
      uvst_pkg::ST_DIV: begin
        // step 0 loads the numerator, then one quotient bit per step
        if (step_r == '0) cmd.div_init = 1'b1;
        else cmd.div_step = 1'b1;
        if (step_r == uvst_pkg::DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = uvst_pkg::ST_CINIT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      uvst_pkg::ST_CINIT: begin
        cmd.cordic_init = 1'b1;
        step_nxt  = '0;
        state_nxt = uvst_pkg::ST_CORDIC;
      end
      uvst_pkg::ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (step_r == uvst_pkg::CORDIC_LAST) begin
          step_nxt  = '0;
          state_nxt = uvst_pkg::ST_STORE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      uvst_pkg::ST_STORE: begin
        cmd.trig_store = 1'b1;
        step_nxt = '0;
        if (ang_r == 2'd3) begin
          res_nxt   = '0;
          state_nxt = uvst_pkg::ST_MUL;
        end else begin
          ang_nxt   = ang_r + 2'd1;
          state_nxt = uvst_pkg::ST_DIV;
        end
      end
      uvst_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (step_r == uvst_pkg::MUL_LAST) begin
          step_nxt  = '0;
          state_nxt = uvst_pkg::ST_EMIT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      uvst_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          priority if (res_r == uvst_pkg::RES_LAST) begin
            cmd.adv_base = 1'b1;
            res_nxt   = '0;
            state_nxt = uvst_pkg::ST_IDLE;
          end else if (res_r < 3'd3) begin
            res_nxt   = res_r + 3'd1;
            step_nxt  = '0;
            state_nxt = uvst_pkg::ST_MUL;
          end else begin
            res_nxt = res_r + 3'd1;
          end
        end
      end
      default: state_nxt = uvst_pkg::ST_IDLE;
    endcase
  end

  `UVST_ASSERT_NOW(a_hs_excl, !(in_tready && out_tvalid), "input and output offered together")
  `UVST_ASSERT_NEXT(a_accept_div, in_tvalid && in_tready,
                    (state_r == uvst_pkg::ST_DIV) && (step_r == 5'd0),
                    "accepted cell did not start the divider")
  `UVST_ASSERT_NEXT(a_last_idle,
                    out_tvalid && out_tready && (res_r == uvst_pkg::RES_LAST),
                    state_r == uvst_pkg::ST_IDLE, "cell not closed after last result")
  `UVST_ASSERT_NOW(a_res_range, res_r <= uvst_pkg::RES_LAST, "result counter out of range")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for uv_sphere_cell_tessellator_top: directed cells, then random cells
// under several register settings, every result checked against an in-bench predictor.
// Depends on uvst_pkg and the tessellator RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;  // no register at this index

  typedef struct {
    bit              vert;
    logic [1:0]      corner;
    logic [16:0]     px, py, pz;
    logic [17:0]     elem;
    bit              last;
  } vertex_rec_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] addr;
    int         data;
    int         si, sj;
    bit         start;
    int         want_base;  // -1: take the predictor's element indices
    bit         zero_pos;   // radius is zero, every coordinate must be zero
  } stim_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  vertex_rec_t cell_results_q[$];
  int          errors = 0;
  int          stall_cnt = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;

  logic [15:0] m_radius;
  logic [8:0]  m_stacks, m_segments;
  logic [17:0] m_base;

  longint atan_turn[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                            21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                            333772, 166886, 83443, 41722, 20861};

  uv_sphere_cell_tessellator_top DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] p;
    bit          neg;
    longint      x, y, z, dx, dy;
    p = {ang, 16'h0};
    neg = 0;
    if (((p + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      p = p ^ 32'h8000_0000;
      neg = 1;
    end
    z = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn[k];
      end else begin
        x += dx; y -= dy; z += atan_turn[k];
      end
    end
    x = (x + 16384) >>> 15;
    y = (y + 16384) >>> 15;
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint eff_div(input logic [8:0] d);
    if (d == 0) return 1;
    if (d > 256) return 256;
    return d;
  endfunction

  function automatic logic [16:0] clip17(input longint v);
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[16:0];
  endfunction

  // Expected six results of one cell; advances the running base.
  function automatic void predict_cell(input int si, input int sj, input bit start);
    longint      s, g, t, cst, sst, csg, ssg, r;
    logic [15:0] a_stk, a_seg;
    vertex_rec_t e;
    logic [1:0]  offs[6] = '{0, 1, 2, 2, 1, 3};
    if (start) m_base = '0;
    s = eff_div(m_stacks);
    g = eff_div(m_segments);
    r = m_radius;
    for (int k = 0; k < 6; k++) begin
      e.vert = k < 4;
      e.corner = k < 4 ? k[1:0] : 2'd0;
      e.px = '0; e.py = '0; e.pz = '0;
      if (k < 4) begin
        t = ((si + (k & 1)) * 32768 + s / 2) / s;
        a_stk = 16'(16384 - t);
        a_seg = 16'(((sj + (k >> 1)) * 65536 + g / 2) / g);
        sin_cos(a_stk, cst, sst);
        sin_cos(a_seg, csg, ssg);
        e.px = clip17((r * cst * ssg + (64'sd1 << 29)) >>> 30);
        e.py = clip17((r * sst + 16384) >>> 15);
        e.pz = clip17((r * cst * csg + (64'sd1 << 29)) >>> 30);
      end
      e.elem = m_base + offs[k];
      e.last = k == 5;
      cell_results_q.push_back(e);
    end
    m_base = m_base + 18'd4;
  endfunction

  task automatic send_cell(input int si, input int sj, input bit start,
                           input int want_base, input bit zero_pos);
    logic [1:0] offs[6] = '{0, 1, 2, 2, 1, 3};
    int         n;
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {sj[7:0], si[7:0]};
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    predict_cell(si, sj, start);
    n = cell_results_q.size();
    for (int k = 0; k < 6; k++) begin
      if (want_base >= 0) cell_results_q[n - 6 + k].elem = 18'(want_base) + offs[k];
      if (zero_pos) begin
        cell_results_q[n - 6 + k].px = '0;
        cell_results_q[n - 6 + k].py = '0;
        cell_results_q[n - 6 + k].pz = '0;
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    do @(posedge clk); while (cell_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] addr, input int value);
    cfg_wr_en <= 1;
    cfg_addr <= addr;
    cfg_wdata <= value[15:0];
    @(posedge clk);
    cfg_wr_en <= 0;
    if (addr == uvst_pkg::REG_RADIUS) m_radius = value[15:0];
    else if (addr == uvst_pkg::REG_STACKS) m_stacks = value[8:0];
    else if (addr == uvst_pkg::REG_SEGMENTS) m_segments = value[8:0];
    @(posedge clk);
  endtask

  function automatic int pick_div();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 256;
      3: return $urandom_range(257, 65535);
      4: return 2;
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= no_idle || $urandom_range(0, 99) >= 14;
      end
    end
  end

  always @(posedge clk) begin
    vertex_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cell_results_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = cell_results_q.pop_front();
        if (out_tuser !== e.vert) begin
          $error("vertex_valid exp %0d got %0d", e.vert, out_tuser); errors++;
        end
        if (out_tdata[1:0] !== e.corner) begin
          $error("corner_number exp %0d got %0d", e.corner, out_tdata[1:0]); errors++;
        end
        if (out_tdata[18:2] !== e.px) begin
          $error("pos_x exp %0h got %0h", e.px, out_tdata[18:2]); errors++;
        end
        if (out_tdata[35:19] !== e.py) begin
          $error("pos_y exp %0h got %0h", e.py, out_tdata[35:19]); errors++;
        end
        if (out_tdata[52:36] !== e.pz) begin
          $error("pos_z exp %0h got %0h", e.pz, out_tdata[52:36]); errors++;
        end
        if (out_tdata[70:53] !== e.elem) begin
          $error("element_index exp %0d got %0d", e.elem, out_tdata[70:53]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_cell exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  stim_row_t dir_rows[] = '{
    '{0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 15, 31, 0, 4, 0},
    '{0, 0, 0, 255, 255, 0, 8, 0},
    '{0, 0, 0, 0, 255, 0, 12, 0},
    '{0, 0, 0, 255, 0, 0, 16, 0},
    '{0, 0, 0, 16, 32, 0, -1, 0},
    '{0, 0, 0, 8, 8, 1, 0, 0},
    '{0, 0, 0, 7, 24, 0, 4, 0},
    '{1, uvst_pkg::REG_RADIUS, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 3, 3, 0, 8, 1},
    '{0, 0, 0, 170, 85, 0, 12, 1},
    '{1, uvst_pkg::REG_RADIUS, 65535, 0, 0, 0, 0, 0},
    '{1, uvst_pkg::REG_STACKS, 0, 0, 0, 0, 0, 0},
    '{1, uvst_pkg::REG_SEGMENTS, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 1, 1, 0, -1, 0},
    '{1, uvst_pkg::REG_STACKS, 511, 0, 0, 0, 0, 0},
    '{1, uvst_pkg::REG_SEGMENTS, 256, 0, 0, 0, 0, 0},
    '{1, REG_UNMAPPED, 65535, 0, 0, 0, 0, 0},
    '{0, 0, 0, 255, 255, 0, -1, 0},
    '{0, 0, 0, 128, 64, 0, -1, 0},
    '{1, uvst_pkg::REG_SEGMENTS, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 85, 170, 0, -1, 0}
  };

  initial begin
    int sent;
    int phase;
    int si, sj;
    m_radius = 16'd256;
    m_stacks = 9'd16;
    m_segments = 9'd32;
    m_base = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[r].addr, dir_rows[r].data);
      end else begin
        send_cell(dir_rows[r].si, dir_rows[r].sj, dir_rows[r].start,
                  dir_rows[r].want_base, dir_rows[r].zero_pos);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 400) begin
      wait_drained();
      write_reg(uvst_pkg::REG_RADIUS,
                phase == 1 ? 65535 : (phase == 4 ? 0 : $urandom_range(0, 65535)));
      write_reg(uvst_pkg::REG_STACKS, pick_div());
      write_reg(uvst_pkg::REG_SEGMENTS, pick_div());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, $urandom_range(0, 65535));
      no_idle = phase == 3;
      if (phase == 2) hold_req = 1;
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 1)) begin
          si = $urandom_range(0, eff_div(m_stacks) - 1);
          sj = $urandom_range(0, eff_div(m_segments) - 1);
        end else begin
          si = $urandom_range(0, 255);
          sj = $urandom_range(0, 255);
        end
        send_cell(si, sj, $urandom_range(0, 15) == 0, -1, 0);
        sent++;
      end
      phase++;
    end
    no_idle = 0;

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && cell_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/uvst_pkg.sv
rtl/core/uvst_dp.sv
rtl/core/uvst_ctrl.sv
rtl/core/uv_sphere_cell_tessellator_top.sv
verif/tb_top.sv
